// ===== sv/s256_pkg.sv =====
// ----------------------------------------------------------------------------
// s256_pkg
// Shared types, round constants and SHA-256 bit functions for the hasher.
// ----------------------------------------------------------------------------
package s256_pkg;

    localparam logic [31:0] PAD_MARKER = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PREP0,
        ST_PREP1,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PREP,
        OP_ROUND,
        OP_FOLD,
        OP_SHIFT
    } t_core_op;

    typedef struct packed {
        t_core_op    op;
        logic        fresh;
        logic [5:0]  rnd;
        logic [2:0]  fidx;
    } t_core_ctl;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== sv/s256_in_if.sv =====
// ----------------------------------------------------------------------------
// s256_in_if
// Message word channel: valid/ready handshake with the word payload.
// ----------------------------------------------------------------------------
interface s256_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_item;

    modport source (output valid, output data_word, output valid_bytes,
                    output last_item, input ready);
    modport sink   (input valid, input data_word, input valid_bytes,
                    input last_item, output ready);
endinterface

// ===== sv/s256_out_if.sv =====
// ----------------------------------------------------------------------------
// s256_out_if
// Digest word channel: valid/ready handshake with the digest payload.
// ----------------------------------------------------------------------------
interface s256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ===== sv/s256_msgbuf.sv =====
// ----------------------------------------------------------------------------
// s256_msgbuf
// Sixteen-word block buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module s256_msgbuf (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [3:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic [3:0]  i_raddr,
    output logic [31:0] o_rdata
);

    logic [31:0] r_mem [0:15];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/s256_chain.sv =====
// ----------------------------------------------------------------------------
// s256_chain
// Eight-word chaining value store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module s256_chain (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [2:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic [2:0]  i_raddr,
    output logic [31:0] o_rdata
);

    logic [31:0] r_mem [0:7];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/s256_core.sv =====
// ----------------------------------------------------------------------------
// s256_core
// Round datapath: working variables a..h, rolling schedule window, the
// precomputed h+K+W term, and the serial fold into the chaining value.
// ----------------------------------------------------------------------------
module s256_core import s256_pkg::*; (
    input  logic        i_clk,
    input  t_core_ctl   i_ctl,
    input  logic [31:0] i_buf_data,
    input  logic [31:0] i_chain_data,
    output logic [31:0] o_head,
    output logic [31:0] o_sum
);

    logic [31:0] r_v     [0:7];
    logic [31:0] r_sched [0:15];
    logic [31:0] r_pre;

    logic [31:0] w_sched;
    logic [31:0] w_next;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] base;
    logic [5:0]  k_idx;

    always_comb begin
        w_sched = sml_sig1(r_sched[14]) + r_sched[9] + sml_sig0(r_sched[1]) + r_sched[0];
        // first sixteen schedule words come straight from the block buffer
        w_next  = (i_ctl.rnd < 6'd15) ? i_buf_data : w_sched;
        k_idx   = i_ctl.rnd + 6'd1;
        t1      = r_pre + big_sig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]));
        t2      = big_sig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        base    = i_ctl.fresh ? init_hash(i_ctl.fidx) : i_chain_data;
        o_sum   = base + r_v[0];
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_PREP: begin
                if (i_ctl.fresh) begin
                    for (int i = 0; i < 8; i++) begin
                        r_v[i] <= init_hash(3'(i));
                    end
                end
                r_pre <= round_k(6'd0) + i_buf_data
                       + (i_ctl.fresh ? init_hash(3'd7) : r_v[7]);
                for (int i = 0; i < 15; i++) begin
                    r_sched[i] <= r_sched[i + 1];
                end
                r_sched[15] <= i_buf_data;
            end
            OP_ROUND: begin
                // g now is h of the next round
                r_pre <= round_k(k_idx) + w_next + r_v[6];
                for (int i = 0; i < 15; i++) begin
                    r_sched[i] <= r_sched[i + 1];
                end
                r_sched[15] <= w_next;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            OP_FOLD: begin
                for (int i = 0; i < 7; i++) begin
                    r_v[i] <= r_v[i + 1];
                end
                r_v[7] <= o_sum;
            end
            OP_SHIFT: begin
                for (int i = 0; i < 7; i++) begin
                    r_v[i] <= r_v[i + 1];
                end
                r_v[7] <= r_v[0];
            end
            default: begin
            end
        endcase
    end

    assign o_head = r_v[0];

endmodule

// ===== sv/sha256_message_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte message streamed as big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Full words are taken one per cycle into a 16-word block buffer; the input
// stalls while the hasher pads, compresses or outputs the digest. A block
// passes through the setup states ST_PREP0 and ST_PREP1, the rounds (one
// round per cycle in the round datapath) and a serial read-add-write over
// the 8-word chaining store. After the last word the padding words are
// written one per cycle (up to 16, or up to 18 when they spill into an extra
// block), the final blocks compress, and the eight digest words follow,
// index 0 first, one per cycle while the sink is ready. The block then holds
// the initial hash values for the next message.
// ----------------------------------------------------------------------------
module sha256_message_hasher import s256_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s256_in_if.sink     i_msg,
    s256_out_if.source  o_dig
);

    t_state      r_state, n_state;
    logic [3:0]  r_pos,   n_pos;
    logic [63:0] r_bits,  n_bits;
    logic [5:0]  r_rnd,   n_rnd;
    logic [2:0]  r_oidx,  n_oidx;
    logic        r_pad,   n_pad;
    logic        r_mark,  n_mark;
    logic        r_hi,    n_hi;
    logic        r_final, n_final;
    logic        r_fresh, n_fresh;

    logic        in_acc;
    logic [2:0]  in_n;
    logic [4:0]  in_sh;
    logic [31:0] in_word;
    logic [31:0] pad_word;

    logic        buf_we;
    logic [3:0]  buf_waddr;
    logic [31:0] buf_wdata;
    logic [3:0]  buf_raddr;
    logic [31:0] buf_rdata;

    logic        chn_we;
    logic [2:0]  chn_waddr;
    logic [2:0]  chn_raddr;
    logic [31:0] chn_rdata;

    t_core_ctl   core_ctl;
    logic [31:0] core_head;
    logic [31:0] core_sum;

    s256_msgbuf u_msgbuf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    s256_chain u_chain (
        .i_clk   (i_clk),
        .i_we    (chn_we),
        .i_waddr (chn_waddr),
        .i_wdata (core_sum),
        .i_raddr (chn_raddr),
        .o_rdata (chn_rdata)
    );

    s256_core u_core (
        .i_clk        (i_clk),
        .i_ctl        (core_ctl),
        .i_buf_data   (buf_rdata),
        .i_chain_data (chn_rdata),
        .o_head       (core_head),
        .o_sum        (core_sum)
    );

    assign i_msg.ready       = (r_state == ST_IDLE);
    assign in_acc            = i_msg.valid & i_msg.ready;
    assign o_dig.valid       = (r_state == ST_OUT);
    assign o_dig.digest_word = core_head;
    assign o_dig.word_index  = r_oidx;
    assign o_dig.last_word   = (r_oidx == 3'd7);

    always_comb begin
        // non-last words and oversized counts carry four bytes
        in_n  = (!i_msg.last_item || i_msg.valid_bytes > 3'd4) ? 3'd4 : i_msg.valid_bytes;
        in_sh = {in_n[1:0], 3'b000};
        if (in_n == 3'd4) begin
            in_word = i_msg.data_word;
        end else begin
            in_word = (i_msg.data_word & ~(32'hFFFF_FFFF >> in_sh)) | (PAD_MARKER >> in_sh);
        end

        if (r_mark) begin
            pad_word = PAD_MARKER;
        end else if (r_pos == 4'd14) begin
            pad_word = r_bits[63:32];
        end else if (r_pos == 4'd15 && r_hi) begin
            pad_word = r_bits[31:0];
        end else begin
            pad_word = 32'd0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_bits   = r_bits;
        n_rnd    = r_rnd;
        n_oidx   = r_oidx;
        n_pad    = r_pad;
        n_mark   = r_mark;
        n_hi     = r_hi;
        n_final  = r_final;
        n_fresh  = r_fresh;

        buf_we    = 1'b0;
        buf_waddr = r_pos;
        buf_wdata = in_word;
        buf_raddr = 4'd0;
        chn_we    = 1'b0;
        chn_waddr = r_rnd[2:0] - 3'd1;
        chn_raddr = r_rnd[2:0];

        core_ctl.op    = OP_HOLD;
        core_ctl.fresh = r_fresh;
        core_ctl.rnd   = r_rnd;
        core_ctl.fidx  = r_rnd[2:0] - 3'd1;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    buf_we = 1'b1;
                    n_pos  = r_pos + 4'd1;
                    n_bits = r_bits + {58'd0, in_n, 3'b000};
                    if (i_msg.last_item) begin
                        n_pad  = 1'b1;
                        n_mark = (in_n == 3'd4);
                        n_hi   = 1'b0;
                    end
                    if (r_pos == 4'd15) begin
                        n_final = 1'b0;
                        n_state = ST_PREP0;
                    end else if (i_msg.last_item) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                buf_we    = 1'b1;
                buf_wdata = pad_word;
                n_pos     = r_pos + 4'd1;
                if (r_mark) begin
                    n_mark = 1'b0;
                end else if (r_pos == 4'd14) begin
                    n_hi = 1'b1;
                end
                if (r_pos == 4'd15) begin
                    n_final = !r_mark && r_hi;
                    n_state = ST_PREP0;
                end
            end
            ST_PREP0: begin
                buf_raddr = 4'd0;
                n_state   = ST_PREP1;
            end
            ST_PREP1: begin
                buf_raddr   = 4'd1;
                core_ctl.op = OP_PREP;
                n_rnd       = 6'd0;
                n_state     = ST_ROUND;
            end
            ST_ROUND: begin
                // prefetch the buffer word two rounds ahead
                buf_raddr   = r_rnd[3:0] + 4'd2;
                core_ctl.op = OP_ROUND;
                n_rnd       = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_rnd   = 6'd0;
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd != 6'd0) begin
                    chn_we      = 1'b1;
                    core_ctl.op = OP_FOLD;
                end
                if (r_rnd == 6'd8) begin
                    n_rnd   = 6'd0;
                    n_fresh = 1'b0;
                    if (r_final) begin
                        n_pad   = 1'b0;
                        n_hi    = 1'b0;
                        n_final = 1'b0;
                        n_bits  = 64'd0;
                        n_oidx  = 3'd0;
                        n_state = ST_OUT;
                    end else if (r_pad) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (o_dig.ready) begin
                    core_ctl.op = OP_SHIFT;
                    n_oidx      = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_fresh = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= 4'd0;
            r_bits  <= 64'd0;
            r_rnd   <= 6'd0;
            r_oidx  <= 3'd0;
            r_pad   <= 1'b0;
            r_mark  <= 1'b0;
            r_hi    <= 1'b0;
            r_final <= 1'b0;
            r_fresh <= 1'b1;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_bits  <= n_bits;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
            r_pad   <= n_pad;
            r_mark  <= n_mark;
            r_hi    <= n_hi;
            r_final <= n_final;
            r_fresh <= n_fresh;
        end
    end

endmodule
